/* rtl/nnids_pkg.sv */
`default_nettype none

package nnids_pkg;

  // Fixed widths of the stream fields and of the register port.
  localparam int PIX_W      = 16;
  localparam int CFG_W      = 11;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Defaults of the top level parameters.
  localparam int DEST_WIDTH_DEF     = 76;
  localparam int DEST_HEIGHT_DEF    = 76;
  localparam int MAX_SOURCE_DIM_DEF = 1024;

  // Source dimensions below this are treated as this value.
  localparam int MIN_SOURCE_DIM = 10;

  // One source pixel feeds at most this many destination indices per axis.
  localparam int MAX_REPEAT = 8;
  localparam int REP_W      = $clog2(MAX_REPEAT + 1);

  localparam logic [CFG_W-1:0] SOURCE_DIM_RESET = CFG_W'(76);

  typedef enum logic [0:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_YSCAN,
    S_XSCAN,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the incoming pixel
    logic wrap;     // fold position counters into the frame, start a row at column 0
    logic scan_x;   // shared compare unit works on the column axis
    logic y_adv;    // cover one more destination row
    logic x_adv;    // cover one more destination column
    logic emit;     // load one write into the output register
    logic advance;  // step to the next source position
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_start;  // the current pixel opens a source row
    logic hit;        // the next pending destination index maps here
    logic none;       // the current pixel produces no write
    logic last;       // the write being loaded is the final one
    logic out_free;   // the output register can take a write
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/nnids_regs.sv */
`default_nettype none

module nnids_regs
  import nnids_pkg::*;
#(
  parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [((CFG_W > $clog2(MAX_SOURCE_DIM) + 1) ? CFG_W
                      : $clog2(MAX_SOURCE_DIM) + 1)-1:0] width_o,
  output logic      [((CFG_W > $clog2(MAX_SOURCE_DIM) + 1) ? CFG_W
                      : $clog2(MAX_SOURCE_DIM) + 1)-1:0] height_o
);

  localparam int CW    = $clog2(MAX_SOURCE_DIM);
  localparam int DIM_W = (CFG_W > CW + 1) ? CFG_W : CW + 1;

  logic [CFG_W-1:0] width_q, height_q;
  reg_idx_e         idx;
  logic             wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SOURCE_DIM_RESET;
      height_q <= SOURCE_DIM_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SOURCE_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_SOURCE_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SOURCE_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_SOURCE_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:           prdata = '0;
    endcase
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(v);
    if (ext < DIM_W'(MIN_SOURCE_DIM)) begin
      return DIM_W'(MIN_SOURCE_DIM);
    end else if (ext > DIM_W'(MAX_SOURCE_DIM)) begin
      return DIM_W'(MAX_SOURCE_DIM);
    end
    return ext;
  endfunction

  assign width_o  = clamp_dim(width_q);
  assign height_o = clamp_dim(height_q);

endmodule

`default_nettype wire

/* rtl/nnids_ctrl.sv */
`default_nettype none

module nnids_ctrl
  import nnids_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = sts_i.row_start ? S_YSCAN : S_XSCAN;
      end
      S_YSCAN: begin
        if (sts_i.hit) begin
          cmd_o.y_adv = 1'b1;
        end else begin
          state_d = S_XSCAN;
        end
      end
      S_XSCAN: begin
        cmd_o.scan_x = 1'b1;
        if (sts_i.hit) begin
          cmd_o.x_adv = 1'b1;
        end else if (sts_i.none) begin
          cmd_o.advance = 1'b1;
          state_d       = S_IDLE;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            cmd_o.advance = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/nnids_dp.sv */
`default_nettype none

module nnids_dp
  import nnids_pkg::*;
#(
  parameter int DEST_WIDTH     = DEST_WIDTH_DEF,
  parameter int DEST_HEIGHT    = DEST_HEIGHT_DEF,
  parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  output dp_sts_t               sts_o,
  input  wire logic [((CFG_W > $clog2(MAX_SOURCE_DIM) + 1) ? CFG_W
                      : $clog2(MAX_SOURCE_DIM) + 1)-1:0] width_i,
  input  wire logic [((CFG_W > $clog2(MAX_SOURCE_DIM) + 1) ? CFG_W
                      : $clog2(MAX_SOURCE_DIM) + 1)-1:0] height_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic [((DEST_WIDTH > 1) ? $clog2(DEST_WIDTH) : 1)-1:0]   dest_x_o,
  output logic [((DEST_HEIGHT > 1) ? $clog2(DEST_HEIGHT) : 1)-1:0] dest_y_o,
  output logic [PIX_W-1:0]      color_o,
  output logic                  run_end_o
);

  localparam int CW    = $clog2(MAX_SOURCE_DIM);
  localparam int DIM_W = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam int XW    = (DEST_WIDTH > 1) ? $clog2(DEST_WIDTH) : 1;
  localparam int YW    = (DEST_HEIGHT > 1) ? $clog2(DEST_HEIGHT) : 1;
  localparam int NXW   = $clog2(DEST_WIDTH + 1);
  localparam int NYW   = $clog2(DEST_HEIGHT + 1);
  localparam int IW    = (NXW > NYW) ? NXW : NYW;
  localparam int PW    = IW + DIM_W;

  // Source position and destination coverage.
  logic [CW-1:0]    src_col_q, src_row_q;
  logic [NXW-1:0]   next_col_q, x_first_q;
  logic [NYW-1:0]   next_row_q, row_first_q;
  logic [REP_W-1:0] row_cnt_q, x_cnt_q, xi_q, yi_q;
  logic             out_valid_q;

  logic [PIX_W-1:0] pixel_q;

  // Folding the position into the current frame size.
  logic          col_ge, row_ge;
  logic [CW:0]   row_a;
  logic [CW-1:0] col_w, row_w;
  logic [NYW-1:0] next_row_w;

  assign col_ge     = DIM_W'(src_col_q) >= width_i;
  assign row_a      = (CW + 1)'(src_row_q) + (CW + 1)'(col_ge);
  assign row_ge     = DIM_W'(row_a) >= height_i;
  assign col_w      = col_ge ? '0 : src_col_q;
  assign row_w      = row_ge ? '0 : row_a[CW-1:0];
  assign next_row_w = row_ge ? '0 : next_row_q;

  // Shared mapping test: index*size < (position+1)*DEST, which is the same
  // as floor(index*size/DEST) <= position.
  logic [IW-1:0]    sc_idx;
  logic [DIM_W-1:0] sc_size;
  logic [CW:0]      sc_pos_p1;
  logic [PW-1:0]    sc_prod, sc_lim;
  logic [REP_W-1:0] sc_cnt;
  logic             sc_room;

  always_comb begin
    if (cmd_i.scan_x) begin
      sc_idx    = IW'(next_col_q);
      sc_size   = width_i;
      sc_pos_p1 = (CW + 1)'(src_col_q) + (CW + 1)'(1);
      sc_lim    = PW'(sc_pos_p1) * PW'(DEST_WIDTH);
      sc_cnt    = x_cnt_q;
      sc_room   = IW'(next_col_q) < IW'(DEST_WIDTH);
    end else begin
      sc_idx    = IW'(next_row_q);
      sc_size   = height_i;
      sc_pos_p1 = (CW + 1)'(src_row_q) + (CW + 1)'(1);
      sc_lim    = PW'(sc_pos_p1) * PW'(DEST_HEIGHT);
      sc_cnt    = row_cnt_q;
      sc_room   = IW'(next_row_q) < IW'(DEST_HEIGHT);
    end
    sc_prod = PW'(sc_idx) * PW'(sc_size);
  end

  logic          xi_end, yi_end;
  logic [CW:0]   col_p1, row_p1;
  logic [NXW:0]  dx_sum;
  logic [NYW:0]  dy_sum;

  assign xi_end = xi_q == (x_cnt_q - REP_W'(1));
  assign yi_end = yi_q == (row_cnt_q - REP_W'(1));
  assign col_p1 = (CW + 1)'(src_col_q) + (CW + 1)'(1);
  assign row_p1 = (CW + 1)'(src_row_q) + (CW + 1)'(1);
  assign dx_sum = (NXW + 1)'(x_first_q) + (NXW + 1)'(xi_q);
  assign dy_sum = (NYW + 1)'(row_first_q) + (NYW + 1)'(yi_q);

  assign sts_o.row_start = col_w == '0;
  assign sts_o.hit       = (sc_cnt < REP_W'(MAX_REPEAT)) && sc_room && (sc_prod < sc_lim);
  assign sts_o.none      = (row_cnt_q == '0) || (x_cnt_q == '0);
  assign sts_o.last      = xi_end && yi_end;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      next_col_q  <= '0;
      next_row_q  <= '0;
      row_first_q <= '0;
      row_cnt_q   <= '0;
      x_first_q   <= '0;
      x_cnt_q     <= '0;
      xi_q        <= '0;
      yi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wrap) begin
        src_col_q  <= col_w;
        src_row_q  <= row_w;
        next_row_q <= next_row_w;
        if (col_w == '0) begin
          row_first_q <= next_row_w;
          row_cnt_q   <= '0;
          next_col_q  <= '0;
          x_first_q   <= '0;
        end else begin
          x_first_q <= next_col_q;
        end
        x_cnt_q <= '0;
        xi_q    <= '0;
        yi_q    <= '0;
      end
      if (cmd_i.y_adv) begin
        next_row_q <= next_row_q + NYW'(1);
        row_cnt_q  <= row_cnt_q + REP_W'(1);
      end
      if (cmd_i.x_adv) begin
        next_col_q <= next_col_q + NXW'(1);
        x_cnt_q    <= x_cnt_q + REP_W'(1);
      end
      if (cmd_i.emit) begin
        if (xi_end) begin
          xi_q <= '0;
          yi_q <= yi_q + REP_W'(1);
        end else begin
          xi_q <= xi_q + REP_W'(1);
        end
      end
      if (cmd_i.advance) begin
        if (DIM_W'(col_p1) >= width_i) begin
          src_col_q <= '0;
          if (DIM_W'(row_p1) >= height_i) begin
            src_row_q  <= '0;
            next_row_q <= '0;
          end else begin
            src_row_q <= row_p1[CW-1:0];
          end
        end else begin
          src_col_q <= col_p1[CW-1:0];
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      pixel_q <= pixel_i;
    end
    if (cmd_i.emit) begin
      dest_x_o  <= dx_sum[XW-1:0];
      dest_y_o  <= dy_sum[YW-1:0];
      color_o   <= pixel_q;
      run_end_o <= xi_end && yi_end;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/nearest_neighbor_image_downscale.sv */
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o    pixel_i
// output    out        out_valid_o/out_stall_i  dest_x_o, dest_y_o, color_o, run_end_o
// config    in         psel/penable/pready      paddr, pwdata, pwrite, prdata
//
// One source pixel is taken only while idle; it then passes a wrap step, a row scan at
// a row start, a column scan and its N writes before the input opens again, where N,
// the writes it produces, is 0 to 64 (destination rows times columns covered). The
// shared index-times-size compare unit steps one destination index per cycle.
// Reset clears the position counters and destination tracking; no clearing pass.
// A stall on the output holds the write in the output register and pauses the run.
module nearest_neighbor_image_downscale
  import nnids_pkg::*;
#(
  parameter int DEST_WIDTH     = DEST_WIDTH_DEF,
  parameter int DEST_HEIGHT    = DEST_HEIGHT_DEF,
  parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [((DEST_WIDTH > 1) ? $clog2(DEST_WIDTH) : 1)-1:0]   dest_x_o,
  output logic [((DEST_HEIGHT > 1) ? $clog2(DEST_HEIGHT) : 1)-1:0] dest_y_o,
  output logic [PIX_W-1:0]           color_o,
  output logic                       run_end_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CW    = $clog2(MAX_SOURCE_DIM);
  localparam int DIM_W = (CFG_W > CW + 1) ? CFG_W : CW + 1;

  logic [DIM_W-1:0] width, height;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  nnids_regs #(
    .MAX_SOURCE_DIM(MAX_SOURCE_DIM)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .width_o (width),
    .height_o(height)
  );

  nnids_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  nnids_dp #(
    .DEST_WIDTH    (DEST_WIDTH),
    .DEST_HEIGHT   (DEST_HEIGHT),
    .MAX_SOURCE_DIM(MAX_SOURCE_DIM)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .width_i    (width),
    .height_i   (height),
    .pixel_i    (pixel_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .dest_x_o   (dest_x_o),
    .dest_y_o   (dest_y_o),
    .color_o    (color_o),
    .run_end_o  (run_end_o)
  );

endmodule

`default_nettype wire

/* rtl/nnids_chk.sv */
`default_nettype none

module nnids_chk
  import nnids_pkg::*;
#(
  parameter int DEST_WIDTH  = DEST_WIDTH_DEF,
  parameter int DEST_HEIGHT = DEST_HEIGHT_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [((DEST_WIDTH > 1) ? $clog2(DEST_WIDTH) : 1)-1:0]   dest_x_o,
  input wire logic [((DEST_HEIGHT > 1) ? $clog2(DEST_HEIGHT) : 1)-1:0] dest_y_o,
  input wire logic [PIX_W-1:0] color_o
);

  // A pixel is worked on alone, so the input closes right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open in the cycle after a transfer");

  // Writes only come out while a pixel is being worked on.
  a_write_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("write appeared without a pixel in progress");

  a_dest_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dest_x_o < DEST_WIDTH) && (dest_y_o < DEST_HEIGHT))
    else $error("destination position outside the image");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(color_o)
      && $stable(dest_x_o) && $stable(dest_y_o))
    else $error("stalled write changed");

endmodule

bind nearest_neighbor_image_downscale nnids_chk #(
  .DEST_WIDTH (DEST_WIDTH),
  .DEST_HEIGHT(DEST_HEIGHT)
) u_nnids_chk (.*);

`default_nettype wire

/* bench/nnids_write_check.sv */
`timescale 1ns / 100ps

module nnids_write_check
  import nnids_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire logic [PIX_W-1:0]      pixel_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire logic [$clog2(DEST_WIDTH_DEF)-1:0]  dest_x_i,
  input  wire logic [$clog2(DEST_HEIGHT_DEF)-1:0] dest_y_i,
  input  wire logic [PIX_W-1:0]      color_i,
  input  wire logic                  run_end_i,
  input  wire logic                  psel_i,
  input  wire logic                  penable_i,
  input  wire logic                  pwrite_i,
  input  wire logic [APB_ADDR_W-1:0] paddr_i,
  input  wire logic [APB_DATA_W-1:0] pwdata_i,
  input  wire logic                  pready_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int DEST_W = DEST_WIDTH_DEF;
  localparam int DEST_H = DEST_HEIGHT_DEF;
  localparam int XW     = $clog2(DEST_W);
  localparam int YW     = $clog2(DEST_H);

  typedef struct packed {
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic [PIX_W-1:0] color;
    logic             run_end;
  } dest_write_t;

  dest_write_t expected_writes[$];

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  // Source position and destination coverage of the scaler.
  logic [9:0]    cur_col;
  logic [9:0]    cur_row;
  logic [XW-1:0] col_cover;
  logic [YW-1:0] row_base;
  logic [3:0]    row_span;
  logic [YW-1:0] row_cover;

  function automatic int effective_dim(input logic [CFG_W-1:0] v);
    if (v < MIN_SOURCE_DIM) return MIN_SOURCE_DIM;
    if (v > MAX_SOURCE_DIM_DEF) return MAX_SOURCE_DIM_DEF;
    return int'(v);
  endfunction

  task automatic predict_writes(input logic [PIX_W-1:0] pix);
    int w, h, col, row, span, x_base, x_span, yi, xi;
    dest_write_t wr;
    w = effective_dim(width_reg);
    h = effective_dim(height_reg);
    col = int'(cur_col);
    row = int'(cur_row);
    // A size change can leave the position outside the frame.
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) begin
      row = 0;
      row_cover = '0;
    end
    if (col == 0) begin
      row_base = row_cover;
      span = 0;
      while (span < MAX_REPEAT && row_cover < DEST_H &&
             (int'(row_cover) * h) / DEST_H <= row) begin
        row_cover = row_cover + 1'b1;
        span++;
      end
      row_span = 4'(span);
      col_cover = '0;
    end
    x_base = int'(col_cover);
    x_span = 0;
    while (x_span < MAX_REPEAT && col_cover < DEST_W &&
           (int'(col_cover) * w) / DEST_W <= col) begin
      col_cover = col_cover + 1'b1;
      x_span++;
    end
    for (yi = 0; yi < int'(row_span); yi++) begin
      for (xi = 0; xi < x_span; xi++) begin
        wr.x       = XW'(x_base + xi);
        wr.y       = YW'(int'(row_base) + yi);
        wr.color   = pix;
        wr.run_end = (yi == int'(row_span) - 1) && (xi == x_span - 1);
        expected_writes.push_back(wr);
      end
    end
    if (col + 1 >= w) begin
      col = 0;
      if (row + 1 >= h) begin
        row = 0;
        row_cover = '0;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
    cur_col = 10'(col);
    cur_row = 10'(row);
  endtask

  task automatic compare_field(input string field, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 'h%0h, got 'h%0h", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dest_write_t want;
    if (!rst_ni) begin
      expected_writes.delete();
      width_reg    = SOURCE_DIM_RESET;
      height_reg   = SOURCE_DIM_RESET;
      cur_col      = '0;
      cur_row      = '0;
      col_cover    = '0;
      row_base     = '0;
      row_span     = '0;
      row_cover    = '0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_writes.size() == 0) begin
          $display("%0t ns: write with none expected, expected nothing, got x=%0d y=%0d color='h%0h run_end=%b",
                   $time, dest_x_i, dest_y_i, color_i, run_end_i);
          fail_count_o++;
        end else begin
          want = expected_writes.pop_front();
          compare_field("dest_x", PIX_W'(want.x), PIX_W'(dest_x_i));
          compare_field("dest_y", PIX_W'(want.y), PIX_W'(dest_y_i));
          compare_field("color", want.color, color_i);
          compare_field("run_end", PIX_W'(want.run_end), PIX_W'(run_end_i));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[2]))
          REG_SOURCE_WIDTH:  width_reg = pwdata_i[CFG_W-1:0];
          REG_SOURCE_HEIGHT: height_reg = pwdata_i[CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_writes(pixel_i);
      end
      pending_o = expected_writes.size();
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import nnids_pkg::*;

  localparam int XW    = $clog2(DEST_WIDTH_DEF);
  localparam int YW    = $clog2(DEST_HEIGHT_DEF);
  localparam int PAD_W = APB_DATA_W - CFG_W;
  // Longest time a pixel that produces no write can still be in flight.
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [XW-1:0]         dest_x;
  logic [YW-1:0]         dest_y;
  logic [PIX_W-1:0]      color;
  logic                  run_end;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;
  logic                  hold_off_req = 1'b0;

  int phase_width[8]  = '{1024, 10, 1024, 76, 11, 152, 1025, 0};
  int phase_height[8] = '{1024, 1024, 10, 76, 13, 38, 9, 2047};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nearest_neighbor_image_downscale dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_i     (pixel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .dest_x_o    (dest_x),
    .dest_y_o    (dest_y),
    .color_o     (color),
    .run_end_o   (run_end),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  nnids_write_check write_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pixel_i      (pixel),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .dest_x_i     (dest_x),
    .dest_y_i     (dest_y),
    .color_i      (color),
    .run_end_i    (run_end),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // Bits above the register are random; only the low bits may count.
    pwdata  <= {PAD_W'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Returns at the edge where the transfer took place.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    in_valid <= 1'b1;
    pixel    <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_all_written();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_bursts(input int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      if (burst > left) burst = left;
      repeat (burst) send_pixel(PIX_W'($urandom_range(0, 16'hFFFF)));
      left -= burst;
      if (left > 0 && $urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // Output side: segments of random stall density, plus one long hold-off on request.
  initial begin : stall_pattern
    int seg_len, pct;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 25;
        2:       pct = 50;
        default: pct = 85;
      endcase
      seg_len = $urandom_range(4, 40);
      repeat (seg_len) begin
        @(posedge clk);
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin : stimulus
    int k, i;
    logic [PIX_W-1:0] walk;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size is 76x76, so each pixel maps to exactly one write.
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hA5A5);
    wait_all_written();

    // Out-of-range sizes are clamped; a 1024-wide source skips most pixels.
    write_reg(REG_SOURCE_WIDTH, 11'd2047);
    write_reg(REG_SOURCE_HEIGHT, 11'd0);
    send_pixel(16'h5A5A);
    send_pixel(16'h0001);
    send_pixel(16'h8000);
    send_pixel(16'hFFFF);
    wait_all_written();

    // Smallest source: every pixel fans out to a block of writes.
    write_reg(REG_SOURCE_WIDTH, 11'd9);
    write_reg(REG_SOURCE_HEIGHT, 11'd10);
    for (k = 0; k < 18; k++) begin
      walk = PIX_W'(1) << (k % PIX_W);
      send_pixel(k[0] ? ~walk : walk);
    end
    wait_all_written();

    // Continue the 10x10 frame, stopping short of its last pixel, with one long output hold-off.
    send_bursts(25);
    hold_off_req = 1'b1;
    repeat (20) send_pixel(PIX_W'($urandom_range(0, 16'hFFFF)));
    send_bursts(35);
    wait_all_written();

    for (i = 0; i < 10; i++) begin
      if (i < 8) begin
        write_reg(REG_SOURCE_WIDTH, CFG_W'(phase_width[i]));
        write_reg(REG_SOURCE_HEIGHT, CFG_W'(phase_height[i]));
      end else begin
        write_reg(REG_SOURCE_WIDTH, CFG_W'($urandom_range(0, 2047)));
        write_reg(REG_SOURCE_HEIGHT, CFG_W'($urandom_range(0, 2047)));
      end
      send_bursts(1);
      wait_all_written();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout: the scaler stopped making progress");
    $display("Some tests failed");
    $finish;
  end

endmodule

/* nearest_neighbor_image_downscale.f */
rtl/nnids_pkg.sv
rtl/nnids_regs.sv
rtl/nnids_ctrl.sv
rtl/nnids_dp.sv
rtl/nearest_neighbor_image_downscale.sv
rtl/nnids_chk.sv
bench/nnids_write_check.sv
bench/tb_top.sv
